// ===== hw/rtl/mcr_pkg.sv =====
// ----------------------------------------------------------------------------
// mcr_pkg
// Shared constants and types of the midpoint circle rasterizer: command codes,
// result slot masks and the job control word passed to the result sequencer.
// ----------------------------------------------------------------------------
package mcr_pkg;

    localparam int COORD_WIDTH_DEF = 12;
    localparam int COLOR_W         = 32;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    // A job lists up to twelve result slots. Slots 0 to 5 cover the octants with
    // (x, y), slots 6 to 11 the octants with x and y swapped. In each half the
    // first two slots are fill spans and the other four are single points.
    localparam int SLOT_COUNT = 12;
    localparam int SLOT_W     = 4;
    localparam int SLOT_HALF  = 6;

    localparam logic [SLOT_COUNT-1:0] MASK_SPAN_A      = 12'h003;
    localparam logic [SLOT_COUNT-1:0] MASK_PTS_A       = 12'h03C;
    localparam logic [SLOT_COUNT-1:0] MASK_SPAN_B      = 12'h0C0;
    localparam logic [SLOT_COUNT-1:0] MASK_PTS_B       = 12'hF00;
    localparam logic [SLOT_COUNT-1:0] MASK_START_LEAD  = 12'h001;
    localparam logic [SLOT_COUNT-1:0] MASK_START_POINT = 12'h004;
    localparam logic [SLOT_COUNT-1:0] MASK_START_RAD   = 12'h508;
    localparam logic [SLOT_COUNT-1:0] MASK_END         = 12'h001;

    typedef struct packed {
        logic [SLOT_COUNT-1:0] mask;
        logic                  is_end;
        logic                  done;
    } job_ctrl_t;

endpackage

// ===== hw/rtl/midpoint_circle_rasterizer.sv =====
// ----------------------------------------------------------------------------
// midpoint_circle_rasterizer
// Midpoint circle walk that turns start and step commands into points, fill
// spans and end markers, one result word per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
// A start word loads a circle and yields one to five results; a step word
// yields four, six, eight or twelve results, or a single end marker. An
// accepted word is registered as a job in the result sequencer, and its results
// then leave at one per cycle, while the output is not stalled, through the
// single result register, which sets the rate. The next command word is
// accepted in the cycle its predecessor's last result is loaded, so the result
// stream has no gaps while commands are ready.
module midpoint_circle_rasterizer
    import mcr_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          cmd,
    input  logic signed [COORD_WIDTH-1:0] center_x,
    input  logic signed [COORD_WIDTH-1:0] center_y,
    input  logic        [COORD_WIDTH-2:0] radius,
    input  logic                          fill,
    input  logic        [COLOR_W-1:0]     color,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [COORD_WIDTH:0]   pix_x,
    output logic signed [COORD_WIDTH:0]   pix_y,
    output logic        [COORD_WIDTH-1:0] span_len,
    output logic        [COLOR_W-1:0]     pix_color,
    output logic                          last,
    output logic                          done_res
);

    job_ctrl_t              job_ctrl;
    logic [COORD_WIDTH-2:0] job_x;
    logic [COORD_WIDTH-2:0] job_y;
    logic [COORD_WIDTH-1:0] job_cx;
    logic [COORD_WIDTH-1:0] job_cy;
    logic [COLOR_W-1:0]     job_color;
    logic                   busy;
    logic                   finishing;
    logic                   load;

    assign in_stall = busy && !finishing;
    assign load     = in_valid && !in_stall;

    mcr_step #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_step (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .cmd       (cmd),
        .center_x  (center_x),
        .center_y  (center_y),
        .radius    (radius),
        .fill      (fill),
        .color     (color),
        .job_ctrl  (job_ctrl),
        .job_x     (job_x),
        .job_y     (job_y),
        .job_cx    (job_cx),
        .job_cy    (job_cy),
        .job_color (job_color)
    );

    mcr_emit #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .job_ctrl  (job_ctrl),
        .job_x     (job_x),
        .job_y     (job_y),
        .job_cx    (job_cx),
        .job_cy    (job_cy),
        .job_color (job_color),
        .out_stall (out_stall),
        .busy      (busy),
        .finishing (finishing),
        .out_valid (out_valid),
        .pix_x     (pix_x),
        .pix_y     (pix_y),
        .span_len  (span_len),
        .pix_color (pix_color),
        .last      (last),
        .done_res  (done_res)
    );

    // An end marker always closes its word and the circle.
    a_end_marker: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (span_len == '0) |-> last && done_res && (pix_x == '0) && (pix_y == '0))
        else $error("end marker with wrong fields");

    // Within a word the result register is refilled in the very next cycle.
    a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last |=> out_valid)
        else $error("gap inside a result list");

    // A new word is only taken when the job slot is empty or draining its last result.
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> !busy || finishing)
        else $error("job overwritten before it was drained");

endmodule

// ===== hw/rtl/mcr_step.sv =====
// ----------------------------------------------------------------------------
// mcr_step
// Circle state and midpoint decision update. Turns each command word into a
// job for the result sequencer and updates the walk state when it is accepted.
// ----------------------------------------------------------------------------
module mcr_step
    import mcr_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          load,
    input  logic                          cmd,
    input  logic signed [COORD_WIDTH-1:0] center_x,
    input  logic signed [COORD_WIDTH-1:0] center_y,
    input  logic        [COORD_WIDTH-2:0] radius,
    input  logic                          fill,
    input  logic        [COLOR_W-1:0]     color,
    output job_ctrl_t                     job_ctrl,
    output logic        [COORD_WIDTH-2:0] job_x,
    output logic        [COORD_WIDTH-2:0] job_y,
    output logic        [COORD_WIDTH-1:0] job_cx,
    output logic        [COORD_WIDTH-1:0] job_cy,
    output logic        [COLOR_W-1:0]     job_color
);

    localparam int RW = COORD_WIDTH - 1;
    localparam int DW = COORD_WIDTH + 2;

    logic [RW-1:0]          step_x_reg, step_x_next;
    logic [RW-1:0]          step_y_reg, step_y_next;
    logic [DW-1:0]          decision_reg, decision_next;
    logic [COORD_WIDTH-1:0] origin_x_reg, origin_x_next;
    logic [COORD_WIDTH-1:0] origin_y_reg, origin_y_next;
    logic                   fill_mode_reg, fill_mode_next;
    logic [COLOR_W-1:0]     draw_color_reg, draw_color_next;
    logic                   active_reg, active_next;

    logic [RW-1:0] y_adv;
    logic [RW-1:0] x_adv;
    logic          dec_pos;
    logic          diag;

    assign dec_pos = !decision_reg[DW-1] && (decision_reg != '0);
    assign y_adv   = step_y_reg + RW'(1);
    assign x_adv   = dec_pos ? step_x_reg - RW'(1) : step_x_reg;
    assign diag    = (x_adv == y_adv);

    always_comb
    begin
        step_x_next     = step_x_reg;
        step_y_next     = step_y_reg;
        decision_next   = decision_reg;
        origin_x_next   = origin_x_reg;
        origin_y_next   = origin_y_reg;
        fill_mode_next  = fill_mode_reg;
        draw_color_next = draw_color_reg;
        active_next     = active_reg;
        job_ctrl.mask   = MASK_END;
        job_ctrl.is_end = 1'b1;
        job_ctrl.done   = 1'b1;
        job_x           = step_x_reg;
        job_y           = step_y_reg;
        if (cmd == CMD_START)
        begin
            origin_x_next   = center_x;
            origin_y_next   = center_y;
            fill_mode_next  = fill;
            draw_color_next = color;
            step_x_next     = radius;
            step_y_next     = '0;
            decision_next   = DW'(1) - {3'b000, radius};
            active_next     = (radius != '0);
            job_ctrl.is_end = 1'b0;
            job_ctrl.done   = (radius == '0);
            job_ctrl.mask   = MASK_START_POINT;
            if (radius != '0)
            begin
                job_ctrl.mask = job_ctrl.mask | MASK_START_RAD;
                if (fill)
                begin
                    job_ctrl.mask = job_ctrl.mask | MASK_START_LEAD;
                end
            end
            job_x = radius;
            job_y = '0;
        end
        else if (active_reg && (step_x_reg > step_y_reg))
        begin
            step_x_next   = x_adv;
            step_y_next   = y_adv;
            decision_next = decision_reg + {2'b00, y_adv, 1'b0} + DW'(1)
                            - (dec_pos ? {2'b00, x_adv, 1'b0} : DW'(0));
            job_x         = x_adv;
            job_y         = y_adv;
            if (x_adv < y_adv)
            begin
                active_next = 1'b0;
            end
            else
            begin
                active_next     = !diag;
                job_ctrl.is_end = 1'b0;
                job_ctrl.done   = diag;
                job_ctrl.mask   = MASK_PTS_A | (fill_mode_reg ? MASK_SPAN_A : '0);
                if (!diag)
                begin
                    job_ctrl.mask = job_ctrl.mask | MASK_PTS_B
                                    | (fill_mode_reg ? MASK_SPAN_B : '0);
                end
            end
        end
        else
        begin
            active_next = 1'b0;
        end
    end

    assign job_cx    = origin_x_next;
    assign job_cy    = origin_y_next;
    assign job_color = draw_color_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_x_reg     <= '0;
            step_y_reg     <= '0;
            decision_reg   <= '0;
            origin_x_reg   <= '0;
            origin_y_reg   <= '0;
            fill_mode_reg  <= 1'b0;
            draw_color_reg <= '0;
            active_reg     <= 1'b0;
        end
        else if (load)
        begin
            step_x_reg     <= step_x_next;
            step_y_reg     <= step_y_next;
            decision_reg   <= decision_next;
            origin_x_reg   <= origin_x_next;
            origin_y_reg   <= origin_y_next;
            fill_mode_reg  <= fill_mode_next;
            draw_color_reg <= draw_color_next;
            active_reg     <= active_next;
        end
    end

endmodule

// ===== hw/rtl/mcr_emit.sv =====
// ----------------------------------------------------------------------------
// mcr_emit
// Result sequencer. Holds one job, walks its slot mask lowest slot first and,
// unless stalled, loads one point, span or end marker per cycle into the result register.
// ----------------------------------------------------------------------------
module mcr_emit
    import mcr_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          load,
    input  job_ctrl_t                     job_ctrl,
    input  logic        [COORD_WIDTH-2:0] job_x,
    input  logic        [COORD_WIDTH-2:0] job_y,
    input  logic        [COORD_WIDTH-1:0] job_cx,
    input  logic        [COORD_WIDTH-1:0] job_cy,
    input  logic        [COLOR_W-1:0]     job_color,
    input  logic                          out_stall,
    output logic                          busy,
    output logic                          finishing,
    output logic                          out_valid,
    output logic signed [COORD_WIDTH:0]   pix_x,
    output logic signed [COORD_WIDTH:0]   pix_y,
    output logic        [COORD_WIDTH-1:0] span_len,
    output logic        [COLOR_W-1:0]     pix_color,
    output logic                          last,
    output logic                          done_res
);

    localparam int RW = COORD_WIDTH - 1;
    localparam int PW = COORD_WIDTH + 1;

    logic [SLOT_COUNT-1:0]  mask_reg, mask_next;
    logic                   is_end_reg;
    logic                   done_reg;
    logic [RW-1:0]          x_reg;
    logic [RW-1:0]          y_reg;
    logic [COORD_WIDTH-1:0] cx_reg;
    logic [COORD_WIDTH-1:0] cy_reg;
    logic [COLOR_W-1:0]     color_reg;

    logic                   out_valid_reg, out_valid_next;
    logic [PW-1:0]          pix_x_reg;
    logic [PW-1:0]          pix_y_reg;
    logic [COORD_WIDTH-1:0] span_len_reg;
    logic [COLOR_W-1:0]     pix_color_reg;
    logic                   last_reg;
    logic                   done_res_reg;

    logic                   adv;
    logic                   emit;
    logic [SLOT_COUNT-1:0]  rest;
    logic [SLOT_W-1:0]      slot;
    logic [SLOT_W-1:0]      k;
    logic                   swap;
    logic                   x_neg;
    logic                   y_neg;
    logic [RW-1:0]          a;
    logic [RW-1:0]          b;
    logic [PW-1:0]          a_ext;
    logic [PW-1:0]          b_ext;
    logic [PW-1:0]          px;
    logic [PW-1:0]          py;
    logic [COORD_WIDTH-1:0] len;

    assign busy      = (mask_reg != '0);
    assign adv       = !out_valid_reg || !out_stall;
    assign emit      = adv && busy;
    assign rest      = mask_reg & (mask_reg - SLOT_COUNT'(1));
    assign finishing = emit && (rest == '0);

    always_comb
    begin
        slot = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
            begin
                slot = SLOT_W'(i);
            end
        end
    end

    assign swap = (slot >= SLOT_W'(SLOT_HALF));
    assign k    = swap ? slot - SLOT_W'(SLOT_HALF) : slot;

    always_comb
    begin
        case (k) inside
            4'd0, 4'd1, 4'd3, 4'd5: x_neg = 1'b1;
            default:                x_neg = 1'b0;
        endcase
        case (k) inside
            4'd1, 4'd4, 4'd5: y_neg = 1'b1;
            default:          y_neg = 1'b0;
        endcase
    end

    assign a     = swap ? y_reg : x_reg;
    assign b     = swap ? x_reg : y_reg;
    assign a_ext = {2'b00, a};
    assign b_ext = {2'b00, b};

    always_comb
    begin
        if (is_end_reg)
        begin
            px  = '0;
            py  = '0;
            len = '0;
        end
        else
        begin
            px  = {cx_reg[COORD_WIDTH-1], cx_reg} + (x_neg ? -a_ext : a_ext);
            py  = {cy_reg[COORD_WIDTH-1], cy_reg} + (y_neg ? -b_ext : b_ext);
            len = (k < SLOT_W'(2)) ? {a, 1'b0} : COORD_WIDTH'(1);
        end
    end

    always_comb
    begin
        mask_next = mask_reg;
        if (load)
        begin
            mask_next = job_ctrl.mask;
        end
        else if (emit)
        begin
            mask_next = rest;
        end
        out_valid_next = out_valid_reg;
        if (adv)
        begin
            out_valid_next = busy;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mask_reg      <= mask_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            is_end_reg <= job_ctrl.is_end;
            done_reg   <= job_ctrl.done;
            x_reg      <= job_x;
            y_reg      <= job_y;
            cx_reg     <= job_cx;
            cy_reg     <= job_cy;
            color_reg  <= job_color;
        end
        if (emit)
        begin
            pix_x_reg     <= px;
            pix_y_reg     <= py;
            span_len_reg  <= len;
            pix_color_reg <= color_reg;
            last_reg      <= (rest == '0);
            done_res_reg  <= done_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign pix_x     = pix_x_reg;
    assign pix_y     = pix_y_reg;
    assign span_len  = span_len_reg;
    assign pix_color = pix_color_reg;
    assign last      = last_reg;
    assign done_res  = done_res_reg;

endmodule

// ===== test/midpoint_circle_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midpoint_circle_checker
// Watches both channels of the circle rasterizer, predicts the point, span and
// end marker words of every accepted command word and compares each result
// word field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module midpoint_circle_checker
    import mcr_pkg::*;
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              in_stall,
    input  logic                              cmd,
    input  logic signed [COORD_WIDTH_DEF-1:0] center_x,
    input  logic signed [COORD_WIDTH_DEF-1:0] center_y,
    input  logic        [COORD_WIDTH_DEF-2:0] radius,
    input  logic                              fill,
    input  logic        [COLOR_W-1:0]         color,
    input  logic                              out_valid,
    input  logic                              out_stall,
    input  logic signed [COORD_WIDTH_DEF:0]   pix_x,
    input  logic signed [COORD_WIDTH_DEF:0]   pix_y,
    input  logic        [COORD_WIDTH_DEF-1:0] span_len,
    input  logic        [COLOR_W-1:0]         pix_color,
    input  logic                              last,
    input  logic                              done_res,
    output int                                errors,
    output int                                pending,
    output int                                words_seen,
    output int                                results_seen
);

    localparam int PW = COORD_WIDTH_DEF + 1;

    typedef struct {
        logic signed [PW-1:0]              px;
        logic signed [PW-1:0]              py;
        logic        [COORD_WIDTH_DEF-1:0] len;
        logic        [COLOR_W-1:0]         col;
        logic                              lst;
        logic                              done;
    } pixel_word_t;

    pixel_word_t pixel_queue[$];
    pixel_word_t word_batch[$];

    logic        [COORD_WIDTH_DEF-2:0] walk_x;
    logic        [COORD_WIDTH_DEF-2:0] walk_y;
    logic signed [13:0]                decision;
    logic signed [COORD_WIDTH_DEF-1:0] org_x;
    logic signed [COORD_WIDTH_DEF-1:0] org_y;
    logic                              fill_on;
    logic        [COLOR_W-1:0]         circle_color;
    logic                              walking;
    int                                mismatch_count;
    int                                word_count;
    int                                result_count;

    task automatic report_mismatch(input string field, input longint got, input longint want);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
        mismatch_count++;
    endtask

    function automatic void add_pixel(input int px, input int py, input int len);
        pixel_word_t w;
        w.px   = px[PW-1:0];
        w.py   = py[PW-1:0];
        w.len  = len[COORD_WIDTH_DEF-1:0];
        w.col  = circle_color;
        w.lst  = 1'b0;
        w.done = 1'b0;
        word_batch.push_back(w);
    endfunction

    function automatic void add_octants(input int cx, input int cy, input int a, input int b);
        if (fill_on)
        begin
            add_pixel(cx - a, cy + b, 2 * a);
            add_pixel(cx - a, cy - b, 2 * a);
        end
        add_pixel(cx + a, cy + b, 1);
        add_pixel(cx - a, cy + b, 1);
        add_pixel(cx + a, cy - b, 1);
        add_pixel(cx - a, cy - b, 1);
    endfunction

    task automatic rasterize_command(
        input logic                              c,
        input logic signed [COORD_WIDTH_DEF-1:0] cx_in,
        input logic signed [COORD_WIDTH_DEF-1:0] cy_in,
        input logic        [COORD_WIDTH_DEF-2:0] r,
        input logic                              f,
        input logic        [COLOR_W-1:0]         col
    );
        int x;
        int y;
        int cx;
        int cy;
        int d;
        bit done;
        word_batch.delete();
        if (c == CMD_START)
        begin
            org_x        = cx_in;
            org_y        = cy_in;
            fill_on      = f;
            circle_color = col;
            walk_x       = r;
            walk_y       = '0;
            decision     = 14'sd1 - $signed({3'b000, r});
            cx = int'(org_x);
            cy = int'(org_y);
            x  = int'(r);
            if (fill_on && x > 0)
            begin
                add_pixel(cx - x, cy, 2 * x);
            end
            add_pixel(cx + x, cy, 1);
            if (x > 0)
            begin
                add_pixel(cx - x, cy, 1);
                add_pixel(cx, cy + x, 1);
                add_pixel(cx, cy - x, 1);
            end
            walking = (x > 0);
            done = !walking;
        end
        else if (!walking || walk_x <= walk_y)
        begin
            walking = 1'b0;
            add_pixel(0, 0, 0);
            done = 1'b1;
        end
        else
        begin
            x = int'(walk_x);
            y = int'(walk_y) + 1;
            if (decision <= 14'sd0)
            begin
                d = int'(decision) + 2 * y + 1;
            end
            else
            begin
                x = x - 1;
                d = int'(decision) + 2 * y - 2 * x + 1;
            end
            decision = d[13:0];
            walk_x = x[COORD_WIDTH_DEF-2:0];
            walk_y = y[COORD_WIDTH_DEF-2:0];
            if (x < y)
            begin
                walking = 1'b0;
                add_pixel(0, 0, 0);
                done = 1'b1;
            end
            else
            begin
                cx = int'(org_x);
                cy = int'(org_y);
                add_octants(cx, cy, x, y);
                if (x != y)
                begin
                    add_octants(cx, cy, y, x);
                end
                walking = (x > y);
                done = !walking;
            end
        end
        word_batch[word_batch.size() - 1].lst = 1'b1;
        foreach (word_batch[i])
        begin
            word_batch[i].done = done;
            pixel_queue.push_back(word_batch[i]);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        pixel_word_t w;
        if (!rst_n)
        begin
            walk_x         = '0;
            walk_y         = '0;
            decision       = '0;
            org_x          = '0;
            org_y          = '0;
            fill_on        = 1'b0;
            circle_color   = '0;
            walking        = 1'b0;
            mismatch_count = 0;
            word_count     = 0;
            result_count   = 0;
            pixel_queue.delete();
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                rasterize_command(cmd, center_x, center_y, radius, fill, color);
                word_count++;
            end
            if (out_valid && !out_stall)
            begin
                result_count++;
                if (pixel_queue.size() == 0)
                begin
                    report_mismatch("unexpected result word, span_len",
                                    longint'(span_len), -64'sd1);
                end
                else
                begin
                    w = pixel_queue.pop_front();
                    if (pix_x !== w.px)
                        report_mismatch("pix_x", longint'(pix_x), longint'(w.px));
                    if (pix_y !== w.py)
                        report_mismatch("pix_y", longint'(pix_y), longint'(w.py));
                    if (span_len !== w.len)
                        report_mismatch("span_len", longint'(span_len), longint'(w.len));
                    if (pix_color !== w.col)
                        report_mismatch("pix_color", longint'(pix_color), longint'(w.col));
                    if (last !== w.lst)
                        report_mismatch("last", longint'(last), longint'(w.lst));
                    if (done_res !== w.done)
                        report_mismatch("done_res", longint'(done_res), longint'(w.done));
                end
            end
        end
        errors       <= mismatch_count;
        pending      <= pixel_queue.size();
        words_seen   <= word_count;
        results_seen <= result_count;
    end

endmodule

// ===== test/midpoint_circle_rasterizer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midpoint_circle_rasterizer_tb
// Drives start and step words into the circle rasterizer, first a directed
// set of edge circles and then random circle walks with random gaps and
// stalls on both channels, and reports the verdict of the checker.
// ----------------------------------------------------------------------------
module midpoint_circle_rasterizer_tb;
    import mcr_pkg::*;

    logic                              clk;
    logic                              rst_n;
    logic                              in_valid;
    logic                              in_stall;
    logic                              cmd;
    logic signed [COORD_WIDTH_DEF-1:0] center_x;
    logic signed [COORD_WIDTH_DEF-1:0] center_y;
    logic        [COORD_WIDTH_DEF-2:0] radius;
    logic                              fill;
    logic        [COLOR_W-1:0]         color;
    logic                              out_valid;
    logic                              out_stall;
    logic signed [COORD_WIDTH_DEF:0]   pix_x;
    logic signed [COORD_WIDTH_DEF:0]   pix_y;
    logic        [COORD_WIDTH_DEF-1:0] span_len;
    logic        [COLOR_W-1:0]         pix_color;
    logic                              last;
    logic                              done_res;

    int errors;
    int pending;
    int words_seen;
    int results_seen;
    int start_count;
    int step_count;
    int random_words;
    bit tx_burst;
    bit rx_burst;

    midpoint_circle_rasterizer uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .center_x  (center_x),
        .center_y  (center_y),
        .radius    (radius),
        .fill      (fill),
        .color     (color),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .pix_x     (pix_x),
        .pix_y     (pix_y),
        .span_len  (span_len),
        .pix_color (pix_color),
        .last      (last),
        .done_res  (done_res)
    );

    midpoint_circle_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cmd          (cmd),
        .center_x     (center_x),
        .center_y     (center_y),
        .radius       (radius),
        .fill         (fill),
        .color        (color),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .pix_x        (pix_x),
        .pix_y        (pix_y),
        .span_len     (span_len),
        .pix_color    (pix_color),
        .last         (last),
        .done_res     (done_res),
        .errors       (errors),
        .pending      (pending),
        .words_seen   (words_seen),
        .results_seen (results_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        #3_000_000;
        $display("Verification failed");
        $finish;
    end

    task automatic send_word(
        input logic                              c,
        input logic signed [COORD_WIDTH_DEF-1:0] cx,
        input logic signed [COORD_WIDTH_DEF-1:0] cy,
        input logic        [COORD_WIDTH_DEF-2:0] r,
        input logic                              f,
        input logic        [COLOR_W-1:0]         col
    );
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd      <= c;
        center_x <= cx;
        center_y <= cy;
        radius   <= r;
        fill     <= f;
        color    <= col;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        if (c == CMD_START)
            start_count++;
        else
            step_count++;
    endtask

    task automatic send_step();
        send_word(CMD_STEP, COORD_WIDTH_DEF'($urandom), COORD_WIDTH_DEF'($urandom),
                  (COORD_WIDTH_DEF-1)'($urandom), 1'($urandom), $urandom);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    initial
    begin
        int rx_wait;
        out_stall = 1'b0;
        rx_burst  = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if ($urandom_range(0, 15) == 0)
                rx_burst = !rx_burst;
            rx_wait = rx_burst ? 0 : $urandom_range(0, 9);
            if (rx_wait > 0)
            begin
                out_stall <= 1'b1;
                repeat (rx_wait) @(negedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
            begin
                @(posedge clk);
            end
            @(negedge clk);
        end
    end

    initial
    begin
        int r;
        int steps;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        cmd          = CMD_START;
        center_x     = '0;
        center_y     = '0;
        radius       = '0;
        fill         = 1'b0;
        color        = '0;
        start_count  = 0;
        step_count   = 0;
        random_words = 0;
        tx_burst     = 1'b0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_step();
        send_word(CMD_START, 12'sd0, 12'sd0, 11'd0, 1'b1, 32'h0000_0000);
        send_step();
        send_word(CMD_START, 12'sd2047, -12'sd2048, 11'd1, 1'b1, 32'hFFFF_FFFF);
        send_step();
        send_word(CMD_START, -12'sd2048, 12'sd2047, 11'd2, 1'b0, 32'hA5A5_A5A5);
        send_step();
        send_step();
        send_word(CMD_START, -12'sd2048, -12'sd2048, 11'd2047, 1'b1, 32'h0000_0000);
        send_step();
        send_step();
        send_word(CMD_START, 12'sd2047, 12'sd2047, 11'd2047, 1'b0, 32'hFFFF_FFFF);
        send_step();
        send_word(CMD_START, 12'sd100, -12'sd100, 11'd5, 1'b1, 32'h5A5A_5A5A);
        repeat (5) send_step();
        drain();

        while (random_words < 160)
        begin
            tx_burst = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) == 0)
            begin
                send_step();
                random_words++;
            end
            else
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    r = $urandom_range(0, 2047);
                    steps = $urandom_range(1, 6);
                end
                else
                begin
                    r = $urandom_range(0, 24);
                    if ($urandom_range(0, 3) == 0)
                        steps = $urandom_range(0, r / 2);
                    else
                        steps = (r * 3) / 4 + 1;
                end
                send_word(CMD_START, COORD_WIDTH_DEF'($urandom), COORD_WIDTH_DEF'($urandom),
                          (COORD_WIDTH_DEF-1)'(r), 1'($urandom), $urandom);
                random_words++;
                repeat (steps)
                begin
                    send_step();
                    random_words++;
                end
            end
            if ($urandom_range(0, 5) == 0)
                drain();
        end
        tx_burst = 1'b0;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);

        if (pending != 0)
            $display("%0d expected result words never arrived", pending);
        $display("Sent %0d command words (%0d starts, %0d steps); checked %0d result words.",
                 words_seen, start_count, step_count, results_seen);
        $display("Covered radius 0 to 2047, fill and outline, idle steps and abandoned walks.");
        if (errors == 0 && pending == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
